// File: src/adpcm_pkg.sv
// Shared types, constants and the filter coefficient table of the ADPCM block decoder.
`default_nettype none
package adpcm_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COEF_W   = 8;
	localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
	localparam int unsigned ACC_W    = 20;
	localparam int unsigned FILT_W   = 3;
	localparam int unsigned SHIFT_W  = 4;
	localparam int unsigned POS_W    = 4;

	localparam logic [FILT_W-1:0] FILT_MAX = 3'd4;
	localparam logic [POS_W-1:0]  POS_HEADER = 4'd0;
	localparam logic [POS_W-1:0]  POS_FLAGS  = 4'd1;
	localparam logic [POS_W-1:0]  POS_LAST   = 4'd15;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 20'sd32767;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -20'sd32768;

	// Control word for the shared multiply-accumulate unit.
	typedef struct packed {
		logic mul_en;    // register a new product
		logic load_acc;  // start the accumulator from the shifted nibble
		logic add_prod;  // fold the scaled product into the accumulator
	} mac_ctrl_t;

	// Weight of the newer history sample for each filter row.
	function automatic logic signed [COEF_W-1:0] coef_newer(input logic [FILT_W-1:0] row);
		logic signed [COEF_W-1:0] c;
		case (row)
			3'd0:    c = 8'sd0;
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			default: c = 8'sd122;
		endcase
		return c;
	endfunction

	// Weight of the older history sample for each filter row.
	function automatic logic signed [COEF_W-1:0] coef_older(input logic [FILT_W-1:0] row);
		logic signed [COEF_W-1:0] c;
		case (row)
			3'd0:    c = 8'sd0;
			3'd1:    c = 8'sd0;
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			default: c = -8'sd60;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: src/adpcm_mac.sv
// Shared multiply-accumulate unit with 16-bit saturation for the filter step.
`default_nettype none
module adpcm_mac (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire adpcm_pkg::mac_ctrl_t                       ctrl,
	input  wire logic signed [adpcm_pkg::SAMPLE_W-1:0]      mul_a,
	input  wire logic signed [adpcm_pkg::COEF_W-1:0]        mul_b,
	input  wire logic signed [adpcm_pkg::SAMPLE_W-1:0]      init_val,
	output logic signed [adpcm_pkg::SAMPLE_W-1:0]           sat_sum
);
	import adpcm_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  scaled;
	logic signed [ACC_W-1:0]  sum;

	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Arithmetic shift right by six is a floor division by 64.
	assign scaled = ACC_W'($signed(prod_q[PROD_W-1:6]));
	assign sum    = acc_q + scaled;

	always_comb begin
		if (sum > SAT_MAX) begin
			sat_sum = SAT_MAX[SAMPLE_W-1:0];
		end else if (sum < SAT_MIN) begin
			sat_sum = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			sat_sum = sum[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			acc_q  <= '0;
		end else begin
			if (ctrl.mul_en) begin
				prod_q <= prod_d;
			end
			if (ctrl.load_acc) begin
				acc_q <= ACC_W'(init_val);
			end else if (ctrl.add_prod) begin
				acc_q <= sum;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/adpcm_block_decoder.sv
// Top level of the ADPCM block decoder: byte sequencer, history and output register.
`default_nettype none
// The decoder takes one encoded byte per input word and turns 16-byte blocks
// into signed 16-bit samples. Byte 0 of a block is the header (shift in the
// low nibble, filter row in the high nibble, rows above four act as four),
// byte 1 is the flags byte, and bytes 2 to 15 each yield two samples, low
// nibble first. A word with key_on set (tuser) clears the two history
// samples and is taken as the header of a new block. The second sample of
// byte 15 carries tlast and the loop-start, loop-end and repeat flags in
// tuser; on every other sample those bits are zero. Header and flags bytes
// are absorbed on acceptance and give no output word. A sample byte is
// accepted and then takes each sample through the states MUL0, MUL1 and
// FIN, since both samples go through a single multiplier and accumulator
// (newer history times its weight, older history times its weight, then
// the final add with saturation). The second sample depends on the first
// through the history, so the two run back to back. A finished sample sits
// in an output register; the decoder accepts the next byte while that
// register waits, and only stalls when a new sample is ready before the
// previous one has been taken.
module adpcm_block_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] key_on
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [15:0] sample
	output logic             m_axis_tlast,   // last_of_block
	output logic [2:0]       m_axis_tuser    // [0] loop_start, [1] loop_end, [2] repeat_res
);
	import adpcm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL0 = 2'd1;
	localparam logic [1:0] ST_MUL1 = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                 state_q;
	logic [POS_W-1:0]           pos_q;
	logic [FILT_W-1:0]          filt_q;
	logic [SHIFT_W-1:0]         shift_q;
	logic [7:0]                 flags_q;
	logic signed [SAMPLE_W-1:0] hist_new_q;
	logic signed [SAMPLE_W-1:0] hist_old_q;
	logic [7:0]                 byte_q;
	logic                       last_q;
	logic                       nib_hi_q;

	logic                       in_fire;
	logic [POS_W-1:0]           pos_eff;
	logic [3:0]                 nib;
	logic signed [SAMPLE_W-1:0] nib_shifted;
	mac_ctrl_t                  mac_ctrl;
	logic signed [SAMPLE_W-1:0] mac_a;
	logic signed [COEF_W-1:0]   mac_b;
	logic signed [SAMPLE_W-1:0] sat_sum;
	logic                       out_load;
	logic                       emit_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Key-on restarts the block at this byte.
	assign pos_eff = s_axis_tuser ? POS_HEADER : pos_q;

	// The nibble goes into the top four bits and is shifted down arithmetically.
	assign nib         = nib_hi_q ? byte_q[7:4] : byte_q[3:0];
	assign nib_shifted = $signed({nib, 12'h000}) >>> shift_q;

	always_comb begin
		mac_ctrl = '0;
		mac_a    = hist_new_q;
		mac_b    = coef_newer(filt_q);
		case (state_q)
			ST_MUL0: begin
				mac_ctrl.mul_en   = 1'b1;
				mac_ctrl.load_acc = 1'b1;
			end
			ST_MUL1: begin
				mac_ctrl.mul_en   = 1'b1;
				mac_ctrl.add_prod = 1'b1;
				mac_a             = hist_old_q;
				mac_b             = coef_older(filt_q);
			end
			default: begin
				mac_ctrl = '0;
			end
		endcase
	end

	adpcm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.mul_a    (mac_a),
		.mul_b    (mac_b),
		.init_val (nib_shifted),
		.sat_sum  (sat_sum)
	);

	// A sample leaves the final add only when the output register is free.
	assign out_load  = (state_q == ST_FIN) && (!m_axis_tvalid || m_axis_tready);
	assign emit_last = nib_hi_q && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			filt_q     <= '0;
			shift_q    <= '0;
			flags_q    <= '0;
			hist_new_q <= '0;
			hist_old_q <= '0;
			byte_q     <= '0;
			last_q     <= 1'b0;
			nib_hi_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser) begin
							hist_new_q <= '0;
							hist_old_q <= '0;
						end
						pos_q <= pos_eff + POS_W'(1);
						if (pos_eff == POS_HEADER) begin
							shift_q <= s_axis_tdata[3:0];
							filt_q  <= (s_axis_tdata[7:4] > 4'(FILT_MAX)) ? FILT_MAX
							         : s_axis_tdata[6:4];
						end else if (pos_eff == POS_FLAGS) begin
							flags_q <= s_axis_tdata;
						end else begin
							byte_q   <= s_axis_tdata;
							last_q   <= (pos_eff == POS_LAST);
							nib_hi_q <= 1'b0;
							state_q  <= ST_MUL0;
						end
					end
				end
				ST_MUL0: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						hist_old_q <= hist_new_q;
						hist_new_q <= sat_sum;
						if (nib_hi_q) begin
							state_q <= ST_IDLE;
						end else begin
							nib_hi_q <= 1'b1;
							state_q  <= ST_MUL0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata    <= sat_sum;
			m_axis_tlast    <= emit_last;
			m_axis_tuser[0] <= emit_last && flags_q[2];
			m_axis_tuser[1] <= emit_last && flags_q[0];
			m_axis_tuser[2] <= emit_last && (flags_q == 8'h03);
		end
	end

endmodule
`default_nettype wire

// File: tb/adpcm_checker.sv
// Checker for the ADPCM block decoder: predicts samples from accepted bytes and compares output words.
`timescale 1ns / 1ps
module adpcm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,
	input  wire logic [2:0]  m_axis_tuser,
	output int               errors,
	output int               pending,
	output int               samples_seen,
	output int               block_ends
);
	import adpcm_pkg::*;

	localparam int          FLAG_LOOP_END   = 0;
	localparam int          FLAG_LOOP_START = 2;
	localparam logic [7:0]  FLAGS_REPEAT    = 8'h03;
	localparam int          SAMPLE_MAX      = 32767;
	localparam int          SAMPLE_MIN      = -32768;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
		logic               loop_start;
		logic               loop_end;
		logic               repeat_res;
	} dec_sample_t;

	dec_sample_t         sample_q[$];
	logic [3:0]          byte_pos;
	logic [2:0]          filt_row;
	logic [3:0]          shift_amt;
	logic [7:0]          block_flags;
	logic signed [15:0]  hist_newer;
	logic signed [15:0]  hist_older;

	// One filter step; the saturated value is pushed into the history.
	function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib);
		logic signed [15:0] scaled;
		int w_new;
		int w_old;
		int acc;
		case (filt_row)
			3'd0: begin
				w_new = 0;
				w_old = 0;
			end
			3'd1: begin
				w_new = 60;
				w_old = 0;
			end
			3'd2: begin
				w_new = 115;
				w_old = -52;
			end
			3'd3: begin
				w_new = 98;
				w_old = -55;
			end
			default: begin
				w_new = 122;
				w_old = -60;
			end
		endcase
		scaled = {nib, 12'h000};
		acc = (int'(scaled) >>> shift_amt)
			+ ((int'(hist_newer) * w_new) >>> 6)
			+ ((int'(hist_older) * w_old) >>> 6);
		if (acc > SAMPLE_MAX)
			acc = SAMPLE_MAX;
		else if (acc < SAMPLE_MIN)
			acc = SAMPLE_MIN;
		hist_older = hist_newer;
		hist_newer = acc[15:0];
		return acc[15:0];
	endfunction

	task automatic compare_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		dec_sample_t lo;
		dec_sample_t hi;
		dec_sample_t want;
		if (!arst_n) begin
			sample_q.delete();
			byte_pos     = POS_HEADER;
			filt_row     = '0;
			shift_amt    = '0;
			block_flags  = '0;
			hist_newer   = '0;
			hist_older   = '0;
			errors       = 0;
			pending      = 0;
			samples_seen = 0;
			block_ends   = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					hist_newer = '0;
					hist_older = '0;
					byte_pos   = POS_HEADER;
				end
				if (byte_pos == POS_HEADER) begin
					shift_amt = s_axis_tdata[3:0];
					filt_row  = (s_axis_tdata[7:4] > FILT_MAX) ? FILT_MAX : s_axis_tdata[6:4];
				end else if (byte_pos == POS_FLAGS) begin
					block_flags = s_axis_tdata;
				end else begin
					lo = '0;
					hi = '0;
					lo.sample = decode_nibble(s_axis_tdata[3:0]);
					hi.sample = decode_nibble(s_axis_tdata[7:4]);
					if (byte_pos == POS_LAST) begin
						hi.last       = 1'b1;
						hi.loop_start = block_flags[FLAG_LOOP_START];
						hi.loop_end   = block_flags[FLAG_LOOP_END];
						hi.repeat_res = (block_flags == FLAGS_REPEAT);
					end
					sample_q.push_back(lo);
					sample_q.push_back(hi);
				end
				byte_pos = byte_pos + 4'd1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (sample_q.size() == 0) begin
					$error("sample word %0d arrived with nothing expected",
						$signed(m_axis_tdata));
					errors++;
				end else begin
					want = sample_q.pop_front();
					samples_seen++;
					if (want.last)
						block_ends++;
					compare_field("sample", int'(want.sample), int'($signed(m_axis_tdata)));
					compare_field("last_of_block", want.last, m_axis_tlast);
					compare_field("loop_start", want.loop_start, m_axis_tuser[0]);
					compare_field("loop_end", want.loop_end, m_axis_tuser[1]);
					compare_field("repeat_res", want.repeat_res, m_axis_tuser[2]);
				end
			end
			pending = sample_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench top for the ADPCM block decoder: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_top;

	// Roughly how many input words the whole run sends, directed part included.
	localparam int ITEMS_TARGET = 1100;
	// Length of the long receiver hold-off in the last phase. With the sender
	// still pushing, the output register and the byte in flight fill up and
	// the decoder has to drop s_axis_tready.
	localparam int HOLD_CYCLES  = 80;
	// Wait after the last expected word, long enough to cover anything still
	// in flight through the decoder.
	localparam int DRAIN_CYCLES = 40;
	// Cycles in a row without any word moved on either side before the run is
	// declared hung. The slowest correct stretch is the hold-off plus a
	// sender gap and the processing of one byte, far below this.
	localparam int WDOG_LIMIT   = 3000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [2:0]  m_axis_tuser;

	int          chk_errors;
	int          chk_pending;
	int          chk_samples;
	int          chk_block_ends;

	// Idle rates in percent, changed between phases by the stimulus process.
	int          src_idle_pct;
	int          sink_idle_pct;
	logic        hold_go;
	int          words_sent;
	int          idle_cycles;

	adpcm_block_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	adpcm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (chk_errors),
		.pending       (chk_pending),
		.samples_seen  (chk_samples),
		.block_ends    (chk_block_ends)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one word. It must be called at a falling edge and returns at the
	// falling edge after the word was taken, so tvalid sees exactly one
	// nonblocking update per time step even for back-to-back words.
	task automatic send_word(input logic [7:0] data, input logic key);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= key;
		do
			@(posedge clk);
		while (!s_axis_tready);
		words_sent++;
		@(negedge clk);
	endtask

	// Sender pause: stop offering and wait until every predicted sample has
	// been delivered.
	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		wait (chk_pending == 0);
		@(negedge clk);
	endtask

	// Receiver: random stalls at the current rate, plus one long hold-off
	// counted here once the stimulus raises hold_go.
	initial begin : receiver
		bit hold_done;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog: any word moving on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("[adpcm_block_decoder] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [8:0] directed_q[$];
		logic [8:0] entry;
		logic [3:0] filt_nib;
		logic [3:0] shift_nib;
		logic [7:0] flag_byte;
		logic [7:0] data;
		int         phase;
		int         phase_end;
		int         len;
		int         i;
		bit         key;
		bit         need_key;
		bit         extreme;
		int         blocks;
		int         keyed;
		int         cut;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		hold_go       = 1'b0;
		src_idle_pct  = 31;
		sink_idle_pct = 49;
		words_sent    = 0;
		blocks        = 0;
		keyed         = 0;
		cut           = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words, {key_on, byte}. A keyed block with the top filter
		// row and zero shift, repeat flags, and runs of the largest positive
		// and negative nibbles to drive both saturation limits, then the
		// zero and all-ones bytes. It wraps straight into a block whose
		// filter index is above four and whose shift is thirteen, carrying
		// both loop flags. That block is cut short by a key-on with shift
		// fourteen and all flag bits set, which in turn is abandoned by a
		// key-on header with shift fifteen.
		directed_q = '{9'h140, 9'h003,
			9'h077, 9'h077, 9'h077, 9'h077, 9'h077, 9'h077,
			9'h088, 9'h088, 9'h088, 9'h088,
			9'h000, 9'h0FF, 9'h080, 9'h008,
			9'h0FD, 9'h005, 9'h07F, 9'h0F8,
			9'h13E, 9'h0FF, 9'h087, 9'h078,
			9'h12F};
		foreach (directed_q[i]) begin
			entry = directed_q[i];
			send_word(entry[7:0], entry[8]);
		end
		drain_outputs();

		// Random blocks in three phases: sender idles more lightly than the
		// receiver, then the other way round, then no idling at all with one
		// long receiver hold-off. Each phase ends with a full drain.
		need_key = 1'b1;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 31;
					sink_idle_pct = 49;
				end
				1: begin
					src_idle_pct  = 49;
					sink_idle_pct = 31;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
					hold_go <= 1'b1;
				end
			endcase
			phase_end = (phase + 1) * ITEMS_TARGET / 3;
			while (words_sent < phase_end) begin
				// Most blocks are complete; a few are cut short. After a cut
				// the next block is normally keyed so the stream realigns, but
				// now and then it is not, which leaves the decoder reading
				// headers and flags as sample bytes.
				len     = ($urandom_range(99) < 10) ? $urandom_range(15, 1) : 16;
				key     = need_key || ($urandom_range(99) < 25);
				extreme = ($urandom_range(99) < 15);
				blocks++;
				if (key)
					keyed++;
				if (len < 16)
					cut++;

				if ($urandom_range(99) < 80)
					filt_nib = 4'($urandom_range(4));
				else
					filt_nib = 4'($urandom_range(15));
				if ($urandom_range(99) < 80)
					shift_nib = 4'($urandom_range(12));
				else
					shift_nib = 4'($urandom_range(15));
				send_word({filt_nib, shift_nib}, key);

				if (len > 1) begin
					if ($urandom_range(2) != 0)
						flag_byte = 8'($urandom_range(7));
					else
						flag_byte = 8'($urandom_range(255));
					send_word(flag_byte, 1'b0);
				end

				for (i = 2; i < len; i++) begin
					if (extreme) begin
						case ($urandom_range(3))
							0:       data = 8'h77;
							1:       data = 8'h88;
							2:       data = 8'h7F;
							default: data = 8'hF8;
						endcase
					end else begin
						data = 8'($urandom_range(255));
					end
					send_word(data, 1'b0);
				end
				need_key = (len != 16) && ($urandom_range(99) < 95);
			end
			drain_outputs();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d words in %0d random blocks (%0d keyed, %0d cut short) plus 25 directed.",
			words_sent, blocks, keyed, cut);
		$display("Compared %0d samples, %0d of them closing a block.",
			chk_samples, chk_block_ends);
		if (chk_errors == 0 && chk_pending == 0)
			$display("[adpcm_block_decoder] OK");
		else
			$display("[adpcm_block_decoder] ERROR");
		$finish;
	end

endmodule
